FILE: design/mmh_pkg.sv
// ----------------------------------------------------------------------------
// mmh_pkg
// Shared types and constants for the 64-bit byte-string hash block.
// ----------------------------------------------------------------------------
package mmh_pkg;

   localparam logic [63:0] MIX_M    = 64'hc6a4a7935bd1e995;
   localparam logic [31:0] MIX_M_LO = MIX_M[31:0];
   localparam logic [31:0] MIX_M_HI = MIX_M[63:32];
   localparam logic [63:0] MIX_SEED = 64'h00000000e17a1465;
   localparam int unsigned MIX_R    = 47;

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        first_word;
      logic        last_word;
      logic [31:0] total_length;
   } req_type;

   typedef struct packed {
      logic [63:0] hash_value;
      logic        length_error;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_EMPTY,
      KIND_TAIL,
      KIND_FULL
   } kind_type;

   // one classified word waiting for the back end
   typedef struct packed {
      kind_type    kind;
      logic [63:0] word;
      logic        first;
      logic        last;
      logic [31:0] total;
      logic        err;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_I,
      ST_SEED_R,
      ST_K1_I,
      ST_K1_R,
      ST_K2_I,
      ST_K2_R,
      ST_H_I,
      ST_H_R,
      ST_FIN_I,
      ST_FIN_R
   } back_state_type;

endpackage

FILE: design/murmur64a_byte_hash_top.sv
// ----------------------------------------------------------------------------
// murmur64a_byte_hash_top
// 64-bit byte-string hash (seed 0xe17a1465) over little-endian 8-byte words.
//
// Request channel (req_valid/req_stall/req_data): one word per request with
// its byte count, first/last marks and, on the first word, the declared
// length. Response channel (rsp_valid/rsp_stall/rsp_data): one hash and an
// error flag per last word.
// The front end takes a request each cycle while its two-entry queue has
// room. The back end shares one two-stage 64-bit multiply-by-constant unit:
// it picks up a word from the queue, then runs one multiply to seed on a
// first word, three for a full word or one for a short word, and one to
// finalize on a last word. A response also waits for the words queued
// ahead of its last word.
// Reset clears the running hash, byte totals, queue and response valid flag.
// A stalled response holds its value; the back end waits at finalization and
// the queue fills, after which req_stall rises.
// ----------------------------------------------------------------------------
module murmur64a_byte_hash_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mmh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mmh_pkg::rsp_type rsp_data
);
   import mmh_pkg::*;

   queue_status_type q_status;
   back_status_type  b_status;
   entry_type        push_entry;
   entry_type        q_head;
   logic             push;

   mmh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   mmh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (b_status.pop),
      .head       (q_head),
      .status     (q_status)
   );

   mmh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_status  (q_status),
      .status    (b_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(b_status.pop && q_status.empty))
      else $error("pop from empty queue");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(b_status.busy))
      else $error("response without back-end work");

   // an empty middle word without a first mark needs no work
   a_pop_starts_work: assert property (@(posedge clock) disable iff (reset)
      b_status.pop && (q_head.first || q_head.last || q_head.kind != KIND_EMPTY)
      |=> b_status.busy)
      else $error("popped word not processed");

endmodule

FILE: design/mmh_queue.sv
// ----------------------------------------------------------------------------
// mmh_queue
// Two-entry queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module mmh_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mmh_pkg::entry_type        push_entry,
   input  logic                      pop,
   output mmh_pkg::entry_type        head,
   output mmh_pkg::queue_status_type status
);
   import mmh_pkg::*;

   entry_type  mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = mem[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

endmodule

FILE: design/mmh_front.sv
// ----------------------------------------------------------------------------
// mmh_front
// Accepts words, tracks byte totals and order faults, classifies each word.
// ----------------------------------------------------------------------------
module mmh_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mmh_pkg::req_type          req_data,
   input  mmh_pkg::queue_status_type q_status,
   output logic                      push,
   output mmh_pkg::entry_type        push_entry
);
   import mmh_pkg::*;

   logic [31:0] seen_ff, seen_in;
   logic [31:0] decl_ff, decl_in;
   logic        fault_ff, fault_in;

   logic [31:0] seen0;
   logic        fault0;
   logic [3:0]  cnt;
   logic [32:0] sum;
   logic [63:0] tail;

   assign req_stall = q_status.full;
   assign push      = req_valid && !req_stall;

   always_comb begin
      decl_in = req_data.first_word ? req_data.total_length : decl_ff;
      seen0   = req_data.first_word ? 32'd0 : seen_ff;
      fault0  = req_data.first_word ? 1'b0 : fault_ff;
      cnt     = (req_data.byte_count > 4'd8) ? 4'd8 : req_data.byte_count;
      fault_in = fault0 || (req_data.byte_count > 4'd8) ||
                 ((cnt < 4'd8) && !req_data.last_word);
      sum = {1'b0, seen0} + 33'(cnt);
      if (sum[32]) begin
         seen_in  = 32'hffffffff;
         fault_in = 1'b1;
      end else begin
         seen_in = sum[31:0];
      end

      for (int i = 0; i < 8; i++) begin
         tail[8*i +: 8] = (4'(i) < cnt) ? req_data.data_word[8*i +: 8] : 8'h00;
      end

      if (cnt == 4'd8) begin
         push_entry.kind = KIND_FULL;
         push_entry.word = req_data.data_word;
      end else if (cnt != 4'd0) begin
         push_entry.kind = KIND_TAIL;
         push_entry.word = tail;
      end else begin
         push_entry.kind = KIND_EMPTY;
         push_entry.word = 64'd0;
      end
      push_entry.first = req_data.first_word;
      push_entry.last  = req_data.last_word;
      push_entry.total = req_data.total_length;
      push_entry.err   = fault_in || (seen_in != decl_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 32'd0;
         decl_ff  <= 32'd0;
         fault_ff <= 1'b0;
      end else if (push) begin
         seen_ff  <= seen_in;
         decl_ff  <= decl_in;
         fault_ff <= fault_in;
      end
   end

endmodule

FILE: design/mmh_mul.sv
// ----------------------------------------------------------------------------
// mmh_mul
// Two-stage multiply by the mix constant, low 64 bits of the product.
// ----------------------------------------------------------------------------
module mmh_mul (
   input  logic        clock,
   input  logic [63:0] operand,
   output logic [63:0] product
);
   import mmh_pkg::*;

   logic [63:0] pp_ll_ff;
   logic [31:0] pp_lh_ff;
   logic [31:0] pp_hl_ff;

   always_ff @(posedge clock) begin
      pp_ll_ff <= 64'(operand[31:0]) * 64'(MIX_M_LO);
      pp_lh_ff <= 32'(operand[31:0] * MIX_M_HI);
      pp_hl_ff <= 32'(operand[63:32] * MIX_M_LO);
   end

   assign product = pp_ll_ff + {pp_lh_ff + pp_hl_ff, 32'd0};

endmodule

FILE: design/mmh_back.sv
// ----------------------------------------------------------------------------
// mmh_back
// Sequencer that seeds, mixes, folds and finalizes the running hash.
// ----------------------------------------------------------------------------
module mmh_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mmh_pkg::entry_type        q_head,
   input  mmh_pkg::queue_status_type q_status,
   output mmh_pkg::back_status_type  status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mmh_pkg::rsp_type          rsp_data
);
   import mmh_pkg::*;

   back_state_type state_ff, state_in;
   entry_type      ent_ff, ent_in;
   logic [63:0]    h_ff, h_in;
   logic [63:0]    opnd_ff, opnd_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   entry_type      ent_cur;
   logic [63:0]    prod;
   logic [63:0]    h_rt;
   logic           route;
   logic           pop;

   mmh_mul u_mul (
      .clock   (clock),
      .operand (opnd_ff),
      .product (prod)
   );

   always_comb begin
      ent_cur      = (state_ff == ST_IDLE) ? q_head : ent_ff;
      state_in     = state_ff;
      ent_in       = ent_ff;
      h_in         = h_ff;
      opnd_in      = opnd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      h_rt         = h_ff;
      route        = 1'b0;
      pop          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               ent_in = q_head;
               if (q_head.first) begin
                  opnd_in  = {32'd0, q_head.total};
                  state_in = ST_SEED_I;
               end else begin
                  route = 1'b1;
               end
            end
         end
         ST_SEED_I: state_in = ST_SEED_R;
         ST_SEED_R: begin
            h_in  = MIX_SEED ^ prod;
            h_rt  = MIX_SEED ^ prod;
            route = 1'b1;
         end
         ST_K1_I: state_in = ST_K1_R;
         ST_K1_R: begin
            opnd_in  = prod ^ (prod >> MIX_R);
            state_in = ST_K2_I;
         end
         ST_K2_I: state_in = ST_K2_R;
         ST_K2_R: begin
            opnd_in  = h_ff ^ prod;
            state_in = ST_H_I;
         end
         ST_H_I: state_in = ST_H_R;
         ST_H_R: begin
            h_in = prod;
            if (ent_ff.last) begin
               opnd_in  = prod ^ (prod >> MIX_R);
               state_in = ST_FIN_I;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN_I: state_in = ST_FIN_R;
         ST_FIN_R: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.hash_value   = prod ^ (prod >> MIX_R);
               rsp_in.length_error = ent_ff.err;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (route) begin
         case (ent_cur.kind)
            KIND_FULL: begin
               opnd_in  = ent_cur.word;
               state_in = ST_K1_I;
            end
            KIND_TAIL: begin
               opnd_in  = h_rt ^ ent_cur.word;
               state_in = ST_H_I;
            end
            default: begin
               if (ent_cur.last) begin
                  opnd_in  = h_rt ^ (h_rt >> MIX_R);
                  state_in = ST_FIN_I;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         h_ff         <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      opnd_ff <= opnd_in;
      rsp_ff  <= rsp_in;
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.pop  = pop;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 64-bit byte-string hash block.
// A queue of words (directed corner cases, then random strings, some well
// formed and some broken) feeds a driver; a scoreboard predicts each hash and
// error flag on acceptance and compares every response in order. The driver
// idles and the response side stalls at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mmh_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SETTLE      = 16;
   localparam int unsigned WORD_TARGET = 850;

   typedef struct {
      req_type req;
      bit      drain;
   } word_item_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   word_item_type word_queue[$];
   rsp_type       hash_expect[$];

   logic [63:0] run_hash;
   logic [31:0] seen_bytes;
   logic [31:0] decl_len;
   logic        seq_fault;

   bit          next_drain = 1'b0;
   bit          calm       = 1'b0;
   bit          req_took   = 1'b0;
   int unsigned gap_left   = 0;
   int unsigned stall_left = 0;
   int unsigned quiet      = 0;
   int unsigned cycles     = 0;
   int unsigned queued     = 0;
   int unsigned words_sent = 0;
   int unsigned hashes_checked = 0;
   int unsigned flagged    = 0;
   int unsigned fails      = 0;

   murmur64a_byte_hash_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // running hash update for one accepted word; returns 1 when a hash is due
   function automatic bit hash_step(input req_type r, output rsp_type o);
      logic [63:0] k;
      logic [63:0] mask;
      logic [63:0] h;
      logic [3:0]  n;
      logic [32:0] sum;
      o = '0;
      if (r.first_word) begin
         decl_len   = r.total_length;
         seen_bytes = '0;
         seq_fault  = 1'b0;
         run_hash   = MIX_SEED ^ ({32'b0, r.total_length} * MIX_M);
      end
      n = r.byte_count;
      if (n > 4'd8) begin
         n = 4'd8;
         seq_fault = 1'b1;
      end
      if (n == 4'd8) begin
         k = r.data_word * MIX_M;
         k = k ^ (k >> MIX_R);
         k = k * MIX_M;
         run_hash = (run_hash ^ k) * MIX_M;
      end else if (n != 4'd0) begin
         mask = (64'd1 << (8 * n)) - 64'd1;
         run_hash = (run_hash ^ (r.data_word & mask)) * MIX_M;
      end
      if (n < 4'd8 && !r.last_word)
         seq_fault = 1'b1;
      sum = {1'b0, seen_bytes} + {29'b0, n};
      if (sum[32]) begin
         seen_bytes = '1;
         seq_fault  = 1'b1;
      end else begin
         seen_bytes = sum[31:0];
      end
      if (!r.last_word)
         return 1'b0;
      h = run_hash;
      h = h ^ (h >> MIX_R);
      h = h * MIX_M;
      h = h ^ (h >> MIX_R);
      o.hash_value   = h;
      o.length_error = seq_fault || (seen_bytes != decl_len);
      return 1'b1;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] rand_data();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0)
         return '0;
      else if (r == 1)
         return '1;
      else
         return {$urandom, $urandom};
   endfunction

   task automatic push_word(input logic [63:0] d, input logic [3:0] c, input bit f,
                            input bit l, input logic [31:0] t);
      word_item_type w;
      w.req.data_word    = d;
      w.req.byte_count   = c;
      w.req.first_word   = f;
      w.req.last_word    = l;
      w.req.total_length = t;
      w.drain            = next_drain;
      next_drain         = 1'b0;
      word_queue.push_back(w);
      queued++;
   endtask

   // one random string: mostly well formed, some with a wrong length, a missing
   // first mark or a short middle word, and some pure noise
   task automatic add_string();
      int unsigned mode;
      int unsigned nfull;
      int unsigned tail;
      int unsigned nwords;
      int unsigned last_cnt;
      int unsigned bad_at;
      logic [31:0] total;
      logic [3:0]  cnt;
      mode  = $urandom_range(0, 19);
      nfull = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 4);
      tail  = $urandom_range(0, 8);
      if (mode >= 17) begin
         repeat ($urandom_range(1, 3))
            push_word(rand_data(), 4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom),
                      $urandom);
         return;
      end
      if (tail == 0 && nfull > 0) begin
         nwords   = nfull;
         last_cnt = 8;
      end else begin
         nwords   = nfull + 1;
         last_cnt = tail;
      end
      total = nfull * 8 + tail;
      if (mode == 15 || mode == 16)
         total = $urandom;
      bad_at = (mode == 14 && nwords > 1) ? $urandom_range(0, nwords - 2) : nwords;
      for (int unsigned i = 0; i < nwords; i++) begin
         cnt = (i == nwords - 1) ? 4'(last_cnt) : 4'd8;
         if (i == bad_at)
            cnt = 4'($urandom_range(0, 7));
         push_word(rand_data(), cnt, (i == 0) && (mode != 13), i == nwords - 1,
                   (i == 0) ? total : $urandom);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (req_valid && !req_took) begin
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (word_queue.size() == 0 || (word_queue[0].drain && quiet < SETTLE)) begin
         req_valid <= 1'b0;
      end else begin
         req_data  <= word_queue[0].req;
         req_valid <= 1'b1;
         word_queue.pop_front();
         gap_left  <= pick_gap();
         if ($urandom_range(0, 63) == 0)
            calm <= !calm;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
   end

   // scoreboard
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d hashes still expected", $time, hash_expect.size());
         $display("simulation failed");
         $finish;
      end else if (reset) begin
         req_took <= 1'b0;
         quiet    <= 0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            words_sent++;
            if (hash_step(req_data, want))
               hash_expect.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (hash_expect.size() == 0) begin
               fails++;
               $display("%0t: unexpected response, expected none, got hash %h err %b",
                        $time, got.hash_value, got.length_error);
            end else begin
               want = hash_expect.pop_front();
               hashes_checked++;
               if (got.length_error)
                  flagged++;
               if (got.hash_value !== want.hash_value) begin
                  fails++;
                  $display("%0t: hash mismatch, expected %h, got %h",
                           $time, want.hash_value, got.hash_value);
               end
               if (got.length_error !== want.length_error) begin
                  fails++;
                  $display("%0t: length error mismatch, expected %b, got %b",
                           $time, want.length_error, got.length_error);
               end
            end
         end
         quiet <= (hash_expect.size() == 0 && !req_valid) ? quiet + 1 : 0;
      end
   end

   initial begin
      run_hash   = '0;
      seen_bytes = '0;
      decl_len   = '0;
      seq_fault  = 1'b0;

      // directed corner cases
      push_word('0, 4'd0, 1'b1, 1'b1, 32'd0);
      for (int unsigned c = 1; c <= 8; c++)
         push_word((c == 8) ? '1 : {$urandom, $urandom}, 4'(c), 1'b1, 1'b1, c);
      push_word('1, 4'd9, 1'b1, 1'b1, 32'd8);
      push_word({$urandom, $urandom}, 4'd15, 1'b1, 1'b1, 32'd8);
      push_word('1, 4'd8, 1'b1, 1'b0, 32'd16);
      push_word('0, 4'd8, 1'b0, 1'b1, '1);
      push_word(64'h0123456789abcdef, 4'd3, 1'b1, 1'b0, 32'd11);
      push_word(64'hfedcba9876543210, 4'd8, 1'b0, 1'b1, 32'd0);
      push_word({$urandom, $urandom}, 4'd5, 1'b0, 1'b1, 32'd5);
      push_word({$urandom, $urandom}, 4'd4, 1'b1, 1'b1, '1);
      push_word({$urandom, $urandom}, 4'd8, 1'b1, 1'b0, 32'd8);
      push_word({$urandom, $urandom}, 4'd0, 1'b0, 1'b0, 32'd0);
      push_word({$urandom, $urandom}, 4'd0, 1'b0, 1'b1, 32'd0);

      // random strings, with a full drain now and then
      next_drain = 1'b1;
      while (queued < WORD_TARGET) begin
         if ($urandom_range(0, 39) == 0)
            next_drain = 1'b1;
         add_string();
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (word_queue.size() != 0 || req_valid)
         @(posedge clock);
      while (hash_expect.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d words sent as %0d strings, %0d flagged with a length error",
               words_sent, hashes_checked, flagged);
      if (fails == 0 && hash_expect.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: files.f
design/mmh_pkg.sv
design/mmh_queue.sv
design/mmh_front.sv
design/mmh_mul.sv
design/mmh_back.sv
design/murmur64a_byte_hash_top.sv
sim/tb.sv
